/* sv/hepe_pkg.sv */
`default_nettype none
package hepe_pkg;

	localparam int MAX_DATA_BITS = 57;
	localparam int CODE_BITS     = 63;
	localparam int PAR_BITS      = 6;
	localparam int LEN_W         = 6;
	localparam int CNT_W         = 3;
	localparam int CHUNK_W       = 8;
	localparam int N_CHUNKS      = (CODE_BITS + CHUNK_W - 1) / CHUNK_W;
	localparam int PAD_W         = N_CHUNKS * CHUNK_W;

	typedef logic [MAX_DATA_BITS-1:0] data_t;
	typedef logic [CODE_BITS-1:0]     code_t;
	typedef logic [LEN_W-1:0]         len_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [N_CHUNKS-1:0]      part_t;

	localparam len_t LEN_RESET = LEN_W'(4);

	typedef struct packed {
		len_t len;
		cnt_t r;
		len_t n;
	} len_info_t;

	// positions (counted from 1) whose index has bit i set
	function automatic code_t par_mask_f(input int i);
		code_t m;
		m = '0;
		for (int p = 1; p <= CODE_BITS; p++) begin
			m[p-1] = ((p >> i) & 1) != 0;
		end
		return m;
	endfunction

	// data bits go LSB first to positions that are not powers of two
	function automatic code_t scatter_f(input data_t d);
		code_t c;
		int    k;
		c = '0;
		k = 0;
		for (int p = 1; p <= CODE_BITS; p++) begin
			if ((p & (p - 1)) != 0) begin
				c[p-1] = d[k];
				k++;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

/* sv/hepe_if.sv */
`default_nettype none
interface hepe_in_if;
	import hepe_pkg::*;
	logic  valid;
	logic  ready;
	data_t data_bits;
	modport source (output valid, output data_bits, input ready);
	modport sink (input valid, input data_bits, output ready);
endinterface

interface hepe_out_if;
	import hepe_pkg::*;
	logic  valid;
	logic  ready;
	code_t codeword;
	cnt_t  parity_count;
	len_t  code_length;
	modport source (output valid, output codeword, output parity_count, output code_length,
		input ready);
	modport sink (input valid, input codeword, input parity_count, input code_length,
		output ready);
endinterface
`default_nettype wire

/* sv/hepe_len_dec.sv */
`default_nettype none
module hepe_len_dec
	import hepe_pkg::*;
(
	input  wire len_t      data_length,
	output len_info_t      info
);

	len_t len;
	cnt_t r;

	always_comb begin
		priority if (data_length == '0) begin
			len = LEN_W'(1);
		end else if (int'(data_length) > MAX_DATA_BITS) begin
			len = LEN_W'(MAX_DATA_BITS);
		end else begin
			len = data_length;
		end
	end

	// smallest r with 2^r >= len + r + 1
	always_comb begin
		r = CNT_W'(PAR_BITS);
		for (int k = PAR_BITS; k >= 1; k--) begin
			if ((1 << k) >= int'(len) + k + 1) begin
				r = CNT_W'(k);
			end
		end
	end

	assign info.len = len;
	assign info.r   = r;
	assign info.n   = len + LEN_W'(r);

endmodule
`default_nettype wire

/* sv/hamming_even_parity_encoder_top.sv */
`default_nettype none
// Hamming encoder with even parity over a configurable data length (1 to 57 bits,
// 0 reads as 1 and larger values as 57). Each data word yields one result: the
// codeword with Hamming position 1 at bit 0 and zeros above code_length, the
// parity count and the code length. Three register stages (length mask, data
// placement with partial parity sums, parity merge into the output register);
// a word may enter every cycle, and the input stalls only when all three
// stages hold words and the output is not taken. Write
// cfg_wr_data with cfg_wr_en only while no transfer is in flight; reset value
// of the length is 4.
module hamming_even_parity_encoder_top
	import hepe_pkg::*;
(
	input  wire           clk,
	input  wire           arst_n,
	input  wire           cfg_wr_en,
	input  wire len_t     cfg_wr_data,
	hepe_in_if.sink       data_ch,
	hepe_out_if.source    code_ch
);

	len_t      data_length_q;
	len_info_t info;

	logic      v_s1, v_s2, v_s3;
	logic      adv1, adv2, adv3;

	data_t     data_s1;
	cnt_t      r_s1, r_s2, r_s3;
	len_t      n_s1, n_s2, n_s3;

	code_t     code_s2, code_s3;
	part_t     part_s2 [PAR_BITS];

	code_t     scat;
	logic [PAD_W-1:0] scat_pad;
	part_t     part_c [PAR_BITS];
	code_t     merged;

	hepe_len_dec u_len_dec (
		.data_length (data_length_q),
		.info        (info)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_length_q <= LEN_RESET;
		end else if (cfg_wr_en) begin
			data_length_q <= cfg_wr_data;
		end
	end

	assign adv3 = !v_s3 || code_ch.ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign data_ch.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= data_ch.valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// stage 1: drop data bits beyond the length
	always_ff @(posedge clk) begin
		if (adv1 && data_ch.valid) begin
			data_s1 <= data_ch.data_bits & ~({MAX_DATA_BITS{1'b1}} << info.len);
			r_s1    <= info.r;
			n_s1    <= info.n;
		end
	end

	// stage 2: place data bits, partial parity per byte
	always_comb begin
		scat     = scatter_f(data_s1);
		scat_pad = PAD_W'(scat);
		for (int i = 0; i < PAR_BITS; i++) begin
			for (int c = 0; c < N_CHUNKS; c++) begin
				part_c[i][c] = ^(scat_pad[c*CHUNK_W +: CHUNK_W]
					& CHUNK_W'(PAD_W'(par_mask_f(i)) >> (c*CHUNK_W)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			code_s2 <= scat;
			part_s2 <= part_c;
			r_s2    <= r_s1;
			n_s2    <= n_s1;
		end
	end

	// stage 3: merge parity bits at power-of-two positions
	always_comb begin
		merged = code_s2;
		for (int i = 0; i < PAR_BITS; i++) begin
			merged[(1 << i) - 1] = ^part_s2[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			code_s3 <= merged;
			r_s3    <= r_s2;
			n_s3    <= n_s2;
		end
	end

	assign code_ch.valid        = v_s3;
	assign code_ch.codeword     = code_s3;
	assign code_ch.parity_count = r_s3;
	assign code_ch.code_length  = n_s3;

endmodule
`default_nettype wire

/* dv/hamming_code_checker.sv */
`default_nettype none
module hamming_code_checker
	import hepe_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       cfg_wr_en,
	input  wire len_t cfg_wr_data,
	hepe_in_if        data_ch,
	hepe_out_if       code_ch,
	output int        mismatches,
	output int        pending
);

	typedef struct packed {
		code_t codeword;
		cnt_t  parity_count;
		len_t  code_length;
	} code_word_t;

	len_t       length_q;
	code_word_t pending_words[$];
	code_word_t oldest;

	initial begin
		mismatches = 0;
		pending    = 0;
	end

	function automatic code_word_t hamming_encode(input len_t length_cfg, input data_t word);
		code_word_t res;
		int         len;
		int         r;
		int         n;
		int         k;
		logic       par;
		len = int'(length_cfg);
		if (len < 1) begin
			len = 1;
		end
		if (len > MAX_DATA_BITS) begin
			len = MAX_DATA_BITS;
		end
		r = 0;
		while ((1 << r) < len + r + 1) begin
			r++;
		end
		n = len + r;
		res.codeword = '0;
		k = 0;
		for (int pos = 1; pos <= n; pos++) begin
			if ((pos & (pos - 1)) != 0) begin
				res.codeword[pos-1] = word[k];
				k++;
			end
		end
		// even parity per check position, data positions only carry bit i
		for (int i = 0; i < r; i++) begin
			par = 1'b0;
			for (int pos = 1; pos <= n; pos++) begin
				if (((pos >> i) & 1) != 0) begin
					par ^= res.codeword[pos-1];
				end
			end
			res.codeword[(1 << i) - 1] = par;
		end
		res.parity_count = cnt_t'(r);
		res.code_length  = len_t'(n);
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (mismatches < 40) begin
			$display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		end
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= LEN_RESET;
		end else begin
			if (cfg_wr_en) begin
				length_q <= cfg_wr_data;
			end
			if (code_ch.valid && code_ch.ready) begin
				if (pending_words.size() == 0) begin
					report_mismatch("unexpected transfer", 64'(code_ch.codeword), '0);
				end else begin
					oldest = pending_words.pop_front();
					if (code_ch.codeword !== oldest.codeword) begin
						report_mismatch("codeword", 64'(code_ch.codeword), 64'(oldest.codeword));
					end
					if (code_ch.parity_count !== oldest.parity_count) begin
						report_mismatch("parity_count", 64'(code_ch.parity_count),
							64'(oldest.parity_count));
					end
					if (code_ch.code_length !== oldest.code_length) begin
						report_mismatch("code_length", 64'(code_ch.code_length),
							64'(oldest.code_length));
					end
				end
			end
			if (data_ch.valid && data_ch.ready) begin
				pending_words.push_back(hamming_encode(length_q, data_ch.data_bits));
			end
			pending = pending_words.size();
		end
	end

endmodule
`default_nettype wire

/* dv/tb_hamming_even_parity_encoder_top.sv */
`default_nettype none
module tb_hamming_even_parity_encoder_top;
	import hepe_pkg::*;

	localparam int HOLD_CYCLES    = 150;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES         = 17;
	localparam int PHASE_WORDS    = 100;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	len_t cfg_wr_data;
	int   mismatches;
	int   pending;
	int   quiet_cycles = 0;
	bit   tx_idle_on;
	bit   rx_idle_on;
	bit   hold_req;

	hepe_in_if  data_ch ();
	hepe_out_if code_ch ();

	hamming_even_parity_encoder_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.data_ch     (data_ch),
		.code_ch     (code_ch)
	);

	hamming_code_checker code_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.data_ch     (data_ch),
		.code_ch     (code_ch),
		.mismatches  (mismatches),
		.pending     (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic send_word(input data_t word);
		data_ch.valid     <= 1'b1;
		data_ch.data_bits <= word;
		do @(posedge clk); while (!data_ch.ready);
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			data_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// stop offering and wait until every transfer has come out
	task automatic drain();
		data_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_length(input int value);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= len_t'(value);
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	function automatic data_t random_word();
		data_t w;
		case ($urandom_range(0, 7))
			0: begin
				w = '0;
			end
			1: begin
				w = '1;
			end
			2: begin
				w = data_t'(1) << $urandom_range(0, MAX_DATA_BITS - 1);
			end
			3: begin
				w = ~(data_t'(1) << $urandom_range(0, MAX_DATA_BITS - 1));
			end
			default: begin
				w = data_t'({$urandom, $urandom});
			end
		endcase
		return w;
	endfunction

	// receiver side
	initial begin
		code_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				code_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				code_ch.ready <= 1'b1;
				hold_req = 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
				code_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				code_ch.ready <= 1'b1;
			end else begin
				code_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((data_ch.valid && data_ch.ready) || (code_ch.valid && code_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int len_pick;
		arst_n            <= 1'b0;
		cfg_wr_en         <= 1'b0;
		cfg_wr_data       <= '0;
		data_ch.valid     <= 1'b0;
		data_ch.data_bits <= '0;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		hold_req   = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// length after reset
		send_word('0);
		send_word('1);
		send_word(data_t'(4'b0101));
		send_word(data_t'(4'b1010));
		// zero length reads as one
		set_length(0);
		send_word('0);
		send_word('1);
		set_length(1);
		send_word(data_t'(1));
		send_word(~data_t'(1));
		// lengths where the parity count steps
		set_length(11);
		send_word('1);
		send_word(data_t'(11'h555));
		set_length(12);
		send_word('1);
		set_length(26);
		send_word('1);
		set_length(27);
		send_word('1);
		set_length(MAX_DATA_BITS);
		send_word('0);
		send_word('1);
		send_word(data_t'(1) << (MAX_DATA_BITS - 1));
		send_word(data_t'(64'h5555_5555_5555_5555));
		send_word(data_t'(64'hAAAA_AAAA_AAAA_AAAA));
		// lengths above the maximum clamp
		set_length(58);
		send_word('1);
		set_length(63);
		send_word('1);
		send_word(data_t'(64'h0123_4567_89AB_CDEF));

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					len_pick = MAX_DATA_BITS;
				end
				1: begin
					len_pick = 0;
				end
				2: begin
					len_pick = 1;
				end
				3: begin
					len_pick = 63;
				end
				4: begin
					len_pick = 4;
				end
				default: begin
					len_pick = $urandom_range(0, 63);
				end
			endcase
			set_length(len_pick);
			tx_idle_on = (ph < PHASES - 2) && (ph != 2) && ($urandom_range(0, 3) != 0);
			rx_idle_on = (ph < PHASES - 2) && ($urandom_range(0, 3) != 0);
			if (ph == 2) begin
				hold_req = 1'b1;
			end
			for (int k = 0; k < PHASE_WORDS; k++) begin
				if (ph == 5 && k == PHASE_WORDS / 2) begin
					drain();
				end
				send_word(random_word());
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
